// File: hw/rtl/mhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhc_pkg
// Shared types, widths and the arctangent table for the magnetometer
// heading core.
// ----------------------------------------------------------------------------
package mhc_pkg;

  localparam int RAW_W      = 16;
  localparam int CORR_W     = 18;
  localparam int OFF_W      = 17;
  localparam int HEAD_W     = 15;

  localparam int DATA_W     = 36;
  localparam int DIG_W      = 9;
  localparam int NDIG       = DATA_W / DIG_W;
  localparam int DIG_CW     = $clog2(NDIG);
  localparam int PRESCALE_SH = 14;

  localparam int ZW         = 27;
  localparam int ANG_FRAC   = 16;
  localparam int HALF_TURN  = 180 * (2 ** ANG_FRAC);
  localparam int FULL_TURN  = 360 * (2 ** ANG_FRAC);
  localparam int ATAN_IDX_W = 5;

  typedef enum logic [1:0] {
    OP_CAL  = 2'd0,
    OP_FIN  = 2'd1,
    OP_MEAS = 2'd2
  } mhc_op_t;

  typedef struct packed {
    logic                     start;
    logic signed [CORR_W-1:0] cx;
    logic signed [CORR_W-1:0] cy;
  } mhc_req_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [ZW-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mhc_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhc_cordic
// Vectoring CORDIC for atan2(cy, cx) with digit-serial x/y adders; returns
// the heading rounded to 2^-HEADING_FRAC_BITS degree in [0, 360).
// ----------------------------------------------------------------------------
module mhc_cordic
  import mhc_pkg::*;
#(
  parameter int CORDIC_STEPS      = 16,
  parameter int HEADING_FRAC_BITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  mhc_req_t          req,
  output logic              done,
  output logic [HEAD_W-1:0] heading
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int SH     = ANG_FRAC - HEADING_FRAC_BITS;
  localparam int HW     = ZW - SH;
  localparam logic [ZW-1:0] HALF      = ZW'(2 ** (SH - 1));
  localparam logic [ZW-1:0] FULL_HALF = ZW'(FULL_TURN + 2 ** (SH - 1));
  localparam logic [HW-1:0] HFULL     = HW'(360 * (2 ** HEADING_FRAC_BITS));
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [DIG_CW-1:0] LAST_DIG  = DIG_CW'(NDIG - 1);

  typedef enum logic [2:0] {
    C_IDLE,
    C_LOAD,
    C_ADD,
    C_ROUND,
    C_WRAP
  } cstate_t;

  cstate_t             state;
  logic [DATA_W-1:0]   x;
  logic [DATA_W-1:0]   y;
  logic [DATA_W-1:0]   opx;
  logic [DATA_W-1:0]   opy;
  logic [ZW-1:0]       z;
  logic [STEP_W-1:0]   i;
  logic [DIG_CW-1:0]   dig;
  logic                dir;
  logic                cx_c;
  logic                cy_c;
  logic [HW-1:0]       h;

  logic                 neg;
  logic [DATA_W-1:0]    cxw;
  logic [DATA_W-1:0]    cyw;
  logic [DATA_W-1:0]    x0;
  logic [DATA_W-1:0]    y0;
  logic [DIG_W-1:0]     bx;
  logic [DIG_W-1:0]     by;
  logic [DIG_W:0]       sumx;
  logic [DIG_W:0]       sumy;
  logic [ZW-1:0]        atan_v;
  logic [ZW-1:0]        zr;
  logic [DATA_W-1:0]    shx;
  logic [DATA_W-1:0]    shy;
  logic                 done_next;

  always_comb begin
    neg    = req.cx[CORR_W-1];
    cxw    = {{(DATA_W-CORR_W){req.cx[CORR_W-1]}}, req.cx};
    cyw    = {{(DATA_W-CORR_W){req.cy[CORR_W-1]}}, req.cy};
    x0     = (neg ? (~cxw + 1'b1) : cxw) << PRESCALE_SH;
    y0     = (neg ? (~cyw + 1'b1) : cyw) << PRESCALE_SH;
    shx    = DATA_W'($signed(y) >>> i);
    shy    = DATA_W'($signed(x) >>> i);
    bx     = opx[DIG_W-1:0] ^ {DIG_W{~dir}};
    by     = opy[DIG_W-1:0] ^ {DIG_W{dir}};
    sumx   = {1'b0, x[DIG_W-1:0]} + {1'b0, bx} + (DIG_W+1)'(cx_c);
    sumy   = {1'b0, y[DIG_W-1:0]} + {1'b0, by} + (DIG_W+1)'(cy_c);
    atan_v = atan_entry(ATAN_IDX_W'(i));
    zr     = z + (z[ZW-1] ? FULL_HALF : HALF);
    done_next = (state == C_IDLE && req.start && req.cx == '0 && req.cy == '0) ||
                (state == C_WRAP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            if (req.cx == '0 && req.cy == '0) begin
              heading <= '0;
            end else begin
              x     <= x0;
              y     <= y0;
              z     <= neg ? ZW'(HALF_TURN) : '0;
              i     <= '0;
              state <= C_LOAD;
            end
          end
        end
        C_LOAD: begin
          opx   <= shx;
          opy   <= shy;
          dir   <= ~y[DATA_W-1];
          cx_c  <= y[DATA_W-1];
          cy_c  <= ~y[DATA_W-1];
          z     <= y[DATA_W-1] ? (z - atan_v) : (z + atan_v);
          dig   <= '0;
          state <= C_ADD;
        end
        C_ADD: begin
          x    <= {sumx[DIG_W-1:0], x[DATA_W-1:DIG_W]};
          y    <= {sumy[DIG_W-1:0], y[DATA_W-1:DIG_W]};
          opx  <= opx >> DIG_W;
          opy  <= opy >> DIG_W;
          cx_c <= sumx[DIG_W];
          cy_c <= sumy[DIG_W];
          if (dig == LAST_DIG) begin
            if (i == LAST_STEP) begin
              state <= C_ROUND;
            end else begin
              i     <= i + 1'b1;
              state <= C_LOAD;
            end
          end else begin
            dig <= dig + 1'b1;
          end
        end
        C_ROUND: begin
          h     <= zr[ZW-1:SH];
          state <= C_WRAP;
        end
        C_WRAP: begin
          heading <= HEAD_W'((h >= HFULL) ? (h - HFULL) : h);
          state   <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == C_IDLE)
    else $error("start while CORDIC busy");
  a_add_dig: assert property (@(posedge clk) disable iff (rst)
    (state == C_ADD && dig != LAST_DIG) |=> state == C_ADD)
    else $error("digit pass cut short");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/magnetometer_heading_with_calibration_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_heading_with_calibration_core
// Hard-iron min/max calibration and atan2 heading for a 3-axis magnetometer.
// ----------------------------------------------------------------------------
// Calibrate and finish items are handled in the idle state and give no result.
// A measure item keeps the block from taking the next item until its result
// is handed off to the output register: each CORDIC iteration is one
// operand-load step plus the four 9-bit digits of the 36-bit x/y adders,
// plus start, round, wrap and hand-off steps. A zero vector skips the
// iterations. The hand-off waits while the output register is still full. Results
// sit in an output register, so a new item is taken while a result waits.
module magnetometer_heading_with_calibration_core
  import mhc_pkg::*;
#(
  parameter int CORDIC_STEPS      = 16,
  parameter int HEADING_FRAC_BITS = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               opcode,
  input  logic signed [RAW_W-1:0]  raw_x,
  input  logic signed [RAW_W-1:0]  raw_z,
  input  logic signed [RAW_W-1:0]  raw_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CORR_W-1:0] corrected_x,
  output logic signed [CORR_W-1:0] corrected_y,
  output logic signed [RAW_W-1:0]  corrected_z,
  output logic [HEAD_W-1:0]        heading
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_HOLD
  } tstate_t;

  tstate_t                  state;
  logic signed [RAW_W-1:0]  max_x;
  logic signed [RAW_W-1:0]  min_x;
  logic signed [RAW_W-1:0]  max_y;
  logic signed [RAW_W-1:0]  min_y;
  logic signed [OFF_W-1:0]  offset_x_half;
  logic signed [OFF_W-1:0]  offset_y_half;
  logic signed [RAW_W-1:0]  pend_z;
  mhc_req_t                 req;

  logic                     acc;
  logic                     out_free;
  logic                     meas_go;
  logic                     out_load;
  logic signed [CORR_W-1:0] cx;
  logic signed [CORR_W-1:0] cy;
  logic                     cdone;
  logic [HEAD_W-1:0]        cheading;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state != T_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign meas_go  = acc && (opcode == OP_MEAS);
  assign out_load = (state == T_HOLD) && out_free;

  always_comb begin
    cx = {raw_x[RAW_W-1], raw_x, 1'b0} - {offset_x_half[OFF_W-1], offset_x_half};
    cy = {raw_y[RAW_W-1], raw_y, 1'b0} - {offset_y_half[OFF_W-1], offset_y_half};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      out_valid     <= 1'b0;
      req.start     <= 1'b0;
      max_x         <= RAW_W'(-32768);
      min_x         <= RAW_W'(32767);
      max_y         <= RAW_W'(-32768);
      min_y         <= RAW_W'(32767);
      offset_x_half <= '0;
      offset_y_half <= '0;
    end else begin
      req.start <= meas_go;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (acc) begin
            unique case (mhc_op_t'(opcode))
              OP_CAL: begin
                if (raw_x > max_x) max_x <= raw_x;
                if (raw_x < min_x) min_x <= raw_x;
                if (raw_y > max_y) max_y <= raw_y;
                if (raw_y < min_y) min_y <= raw_y;
              end
              OP_FIN: begin
                offset_x_half <= OFF_W'(max_x) + OFF_W'(min_x);
                offset_y_half <= OFF_W'(max_y) + OFF_W'(min_y);
              end
              OP_MEAS: begin
                req.cx    <= cx;
                req.cy    <= cy;
                pend_z    <= raw_z;
                state     <= T_BUSY;
              end
              default: ;
            endcase
          end
        end
        T_BUSY: begin
          if (cdone) state <= T_HOLD;
        end
        T_HOLD: begin
          if (out_free) begin
            corrected_x <= req.cx;
            corrected_y <= req.cy;
            corrected_z <= pend_z;
            heading     <= cheading;
            state       <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  mhc_cordic #(
    .CORDIC_STEPS      (CORDIC_STEPS),
    .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .done    (cdone),
    .heading (cheading)
  );

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    cdone |-> state == T_BUSY)
    else $error("CORDIC done outside busy");
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    (acc && opcode == OP_CAL) |=> (max_x >= min_x && max_y >= min_y))
    else $error("calibration range inverted");
  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == T_HOLD)
    else $error("result shown without finished measure");
`endif

endmodule
`default_nettype wire

// File: tb/mhc_tb_pkg.sv
// ----------------------------------------------------------------------------
// mhc_tb_pkg
// Scoreboard for the magnetometer heading core: keeps its own copy of the
// min/max calibration state and offsets, computes the corrected axes and the
// CORDIC heading for every measure transfer, and checks results in order.
// ----------------------------------------------------------------------------
package mhc_tb_pkg;
  import mhc_pkg::*;

  localparam int CORDIC_STEPS      = 16;
  localparam int HEADING_FRAC_BITS = 6;
  localparam int ATAN_LEN          = 24;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // atan(2^-i) in 2^-16 degree
  localparam longint ATAN_DEG [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [CORR_W-1:0] cx;
    logic signed [CORR_W-1:0] cy;
    logic signed [RAW_W-1:0]  cz;
    logic [HEAD_W-1:0]        hd;
  } meas_result_t;

  class heading_scoreboard;
    int max_x, min_x, max_y, min_y;
    int off_x, off_y;
    meas_result_t awaited[$];
    int mismatches;

    function new();
      max_x = -32768;
      min_x = 32767;
      max_y = -32768;
      min_y = 32767;
      off_x = 0;
      off_y = 0;
      mismatches = 0;
    endfunction

    static function logic [HEAD_W-1:0] cordic_heading(longint cx, longint cy);
      longint x, y, z, dx, dy, h, wrap;
      if (cx == 0 && cy == 0) return '0;
      x = cx <<< PRESCALE_SH;
      y = cy <<< PRESCALE_SH;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = longint'(180) <<< ANG_FRAC;
      end
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += ATAN_DEG[i];
        end else begin
          x -= dx;
          y += dy;
          z -= ATAN_DEG[i];
        end
      end
      if (z < 0) z += longint'(360) <<< ANG_FRAC;
      h = (z + (longint'(1) <<< (ANG_FRAC - HEADING_FRAC_BITS - 1)))
          >>> (ANG_FRAC - HEADING_FRAC_BITS);
      wrap = longint'(360) <<< HEADING_FRAC_BITS;
      while (h >= wrap) h -= wrap;
      return h[HEAD_W-1:0];
    endfunction

    function void note_transfer(logic [1:0] op, logic signed [RAW_W-1:0] rx,
                                logic signed [RAW_W-1:0] rz,
                                logic signed [RAW_W-1:0] ry);
      meas_result_t m;
      longint cx, cy;
      if (op == OP_CAL) begin
        if (int'(rx) > max_x) max_x = rx;
        if (int'(rx) < min_x) min_x = rx;
        if (int'(ry) > max_y) max_y = ry;
        if (int'(ry) < min_y) min_y = ry;
      end else if (op == OP_FIN) begin
        off_x = max_x + min_x;
        off_y = max_y + min_y;
      end else if (op == OP_MEAS) begin
        cx = 2 * longint'(rx) - off_x;
        cy = 2 * longint'(ry) - off_y;
        m.cx = cx[CORR_W-1:0];
        m.cy = cy[CORR_W-1:0];
        m.cz = rz;
        m.hd = cordic_heading(cx, cy);
        awaited.push_back(m);
      end
    endfunction

    function void check_transfer(meas_result_t got);
      meas_result_t exp;
      if (awaited.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: x %0d y %0d z %0d heading %0d",
                   got.cx, got.cy, got.cz, got.hd);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (got.cx !== exp.cx || got.cy !== exp.cy || got.cz !== exp.cz ||
          got.hd !== exp.hd) begin
        if (mismatches < 10)
          $display("mismatch: exp x %0d y %0d z %0d heading %0d, got x %0d y %0d z %0d heading %0d",
                   exp.cx, exp.cy, exp.cz, exp.hd, got.cx, got.cy, got.cz, got.hd);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: tb/magnetometer_heading_with_calibration_core_tb.sv
// ----------------------------------------------------------------------------
// magnetometer_heading_with_calibration_core_tb
// Drives calibrate, finish and measure transfers into the heading core with
// random gaps and stalls on both sides, and checks every result against the
// scoreboard's prediction of the corrected axes and heading.
// ----------------------------------------------------------------------------
module magnetometer_heading_with_calibration_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mhc_pkg::*;
  import mhc_tb_pkg::*;

  localparam int ITEM_TARGET    = 1100;
  localparam int LONG_HOLD      = 800;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [1:0] opcode = OP_CAL;
  logic signed [RAW_W-1:0] raw_x = '0;
  logic signed [RAW_W-1:0] raw_z = '0;
  logic signed [RAW_W-1:0] raw_y = '0;
  logic in_stall;
  logic out_valid;
  logic signed [CORR_W-1:0] corrected_x;
  logic signed [CORR_W-1:0] corrected_y;
  logic signed [RAW_W-1:0] corrected_z;
  logic [HEAD_W-1:0] heading;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_request = 1'b0;
  int items_sent = 0;
  heading_scoreboard sb = new();

  magnetometer_heading_with_calibration_core #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .HEADING_FRAC_BITS(HEADING_FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .raw_x(raw_x),
    .raw_z(raw_z),
    .raw_y(raw_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .corrected_x(corrected_x),
    .corrected_y(corrected_y),
    .corrected_z(corrected_z),
    .heading(heading)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(20, 150));
    return int'($urandom_range(1, 4));
  endfunction

  function automatic logic signed [RAW_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[RAW_W-1:0];
  endfunction

  function automatic logic signed [RAW_W-1:0] edge_value();
    case ($urandom_range(0, 3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic signed [RAW_W-1:0] x,
                           input logic signed [RAW_W-1:0] z,
                           input logic signed [RAW_W-1:0] y);
    int gap;
    gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    raw_x    <= x;
    raw_z    <= z;
    raw_y    <= y;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_transfer(op, x, z, y);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  // receiver back-pressure
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // result monitor and watchdog
  initial begin
    int idle_cycles;
    meas_result_t got;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst) begin
        idle_cycles = 0;
      end else if (out_valid === 1'b1 && out_stall == 1'b0) begin
        got.cx = corrected_x;
        got.cy = corrected_y;
        got.cz = corrected_z;
        got.hd = heading;
        sb.check_transfer(got);
        idle_cycles = 0;
      end else if (in_valid && in_stall === 1'b0) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int phase, ncal, nmeas, cen_x, cen_y, spread;
    logic signed [RAW_W-1:0] x, y, z;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero offsets: zero vector, axes and extremes
    tx_calm = 1'b1;
    send_item(OP_MEAS, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_MEAS, 16'sd32767, 16'sd32767, 16'sd0);
    send_item(OP_MEAS, -16'sd32768, -16'sd32768, 16'sd0);
    send_item(OP_MEAS, 16'sd0, -16'sd1, 16'sd32767);
    send_item(OP_MEAS, 16'sd0, 16'sd1, -16'sd32768);
    send_item(OP_MEAS, -16'sd1, 16'sd0, -16'sd1);
    send_item(OP_MEAS, 16'sd32767, 16'sd5, -16'sd32768);
    send_item(OP_UNUSED, 16'sd1234, -16'sd77, -16'sd4321);
    // finish with no calibration samples: offsets of -1
    send_item(OP_FIN, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_MEAS, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_MEAS, -16'sd32768, 16'sd3, -16'sd32768);
    // single low sample: both offsets at the negative limit
    send_item(OP_CAL, -16'sd32768, 16'sd32767, -16'sd32768);
    send_item(OP_FIN, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_MEAS, 16'sd32767, -16'sd9, 16'sd32767);
    send_item(OP_MEAS, -16'sd32768, 16'sd0, -16'sd32768);
    send_item(OP_MEAS, -16'sd32768, 16'sd0, 16'sd32767);
    // range keeps widening across finishes
    send_item(OP_CAL, -16'sd32760, 16'sd0, -16'sd32760);
    send_item(OP_FIN, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_MEAS, -16'sd32764, 16'sd0, -16'sd32764);
    send_item(OP_MEAS, -16'sd32764, 16'sd0, -16'sd32000);
    send_item(OP_UNUSED, -16'sd1, -16'sd1, -16'sd1);
    wait_drained();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      ncal   = int'($urandom_range(0, 6));
      cen_x  = int'($urandom_range(0, 40000)) - 20000;
      cen_y  = int'($urandom_range(0, 40000)) - 20000;
      spread = 1 << $urandom_range(2, 14);
      repeat (ncal) begin
        if ($urandom_range(0, 7) == 0)
          send_item(OP_CAL, 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_item(OP_CAL,
                    clamp16(cen_x + int'($urandom_range(0, 2 * spread)) - spread),
                    16'($urandom),
                    clamp16(cen_y + int'($urandom_range(0, 2 * spread)) - spread));
      end
      if ($urandom_range(0, 3) != 0)
        send_item(OP_FIN, 16'($urandom), 16'($urandom), 16'($urandom));

      // fill the core behind a long output hold
      if (phase == 3) begin
        tx_calm = 1'b1;
        hold_request = 1'b1;
      end

      nmeas = int'($urandom_range(8, 40));
      repeat (nmeas) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        x = 16'($urandom);
        y = 16'($urandom);
        case ($urandom_range(0, 7))
          0: begin
            x = clamp16((sb.off_x >>> 1) + int'($urandom_range(0, 4)) - 2);
            y = clamp16((sb.off_y >>> 1) + int'($urandom_range(0, 4)) - 2);
          end
          1: x = clamp16(sb.off_x >>> 1);
          2: y = clamp16(sb.off_y >>> 1);
          3: begin
            x = edge_value();
            y = edge_value();
          end
          default: ;
        endcase
        z = ($urandom_range(0, 7) == 0) ? edge_value() : 16'($urandom);
        send_item(OP_MEAS, x, z, y);
      end
      if (phase == 2 || $urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
